[rtl/core/osa_ed_pkg.sv]
package osa_ed_pkg;

  localparam logic [1:0] MODE_FIRST   = 2'd0;
  localparam logic [1:0] MODE_SECOND  = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  localparam int unsigned DIST_MAX = 127;

  typedef struct packed {
    logic busy;       // input side held off
    logic first_row;  // start of compute: fetch first char of string one
    logic row_load;   // latch row char, seed left-edge values
    logic sweep;      // one cell per cycle along the row
    logic row_end;    // rotate row buffers, fetch next row char
    logic finish;     // load result register, clear strings
  } osa_ed_cmd_t;

  typedef struct packed {
    logic n1_zero;
    logic n2_zero;
    logic last_col;
    logic last_row;
    logic out_free;
  } osa_ed_status_t;

endpackage

[rtl/core/osa_ed_ram.sv]
module osa_ed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/osa_ed_ctrl.sv]
module osa_ed_ctrl
  import osa_ed_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     mode,
  input  osa_ed_status_t status,
  output osa_ed_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_ROW_LOAD,
    S_SWEEP,
    S_ROW_END,
    S_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && mode == MODE_COMPUTE) state <= S_START;
        end
        S_START: begin
          if (status.n1_zero || status.n2_zero) state <= S_FINISH;
          else state <= S_ROW_LOAD;
        end
        S_ROW_LOAD: state <= S_SWEEP;
        S_SWEEP: begin
          if (status.last_col) state <= status.last_row ? S_FINISH : S_ROW_END;
        end
        S_ROW_END: state <= S_ROW_LOAD;
        S_FINISH: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.busy      = (state != S_IDLE);
    cmd.first_row = (state == S_START);
    cmd.row_load  = (state == S_ROW_LOAD);
    cmd.sweep     = (state == S_SWEEP);
    cmd.row_end   = (state == S_ROW_END);
    cmd.finish    = (state == S_FINISH) && status.out_free;
  end

endmodule

[rtl/core/osa_ed_dpath.sv]
module osa_ed_dpath
  import osa_ed_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     mode,
  input  logic [7:0]     char_code,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  input  logic           out_stall,
  output logic           out_valid,
  output logic [6:0]     distance,
  output logic           overflow,
  input  osa_ed_cmd_t    cmd,
  output osa_ed_status_t status
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int W  = $clog2(MAX_LEN + 2);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic          use_tr;
  logic [LW-1:0] n1, n2;
  logic          ovf;
  logic [1:0]    cur_sel;
  logic [AW-1:0] ri, col;
  logic [7:0]    a, a_prev, b_prev;
  logic [W-1:0]  cur_left, prev_left, o1, o2;

  logic          take, app1, app2, full1, full2;
  logic [AW-1:0] t1_raddr, row_raddr;
  logic [7:0]    t1_rdata, t2_rdata;
  logic [W-1:0]  row_rdata [3];
  logic [1:0]    prev_sel, older_sel;
  logic [W-1:0]  j, prev_j, older_j, sub, v0, v1, v, result;

  assign take  = in_valid && !cmd.busy;
  assign full1 = (n1 >= LW'(MAX_LEN));
  assign full2 = (n2 >= LW'(MAX_LEN));
  assign app1  = take && mode == MODE_FIRST && !full1;
  assign app2  = take && mode == MODE_SECOND && !full2;

  assign t1_raddr  = cmd.first_row ? '0 : ri + AW'(1);
  assign row_raddr = cmd.row_load ? '0 : col + AW'(1);

  osa_ed_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text1 (
    .clk(clk), .we(app1), .waddr(n1[AW-1:0]), .wdata(char_code),
    .raddr(t1_raddr), .rdata(t1_rdata)
  );

  osa_ed_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text2 (
    .clk(clk), .we(app2), .waddr(n2[AW-1:0]), .wdata(char_code),
    .raddr(row_raddr), .rdata(t2_rdata)
  );

  // three row buffers rotate through current / previous / older roles
  for (genvar k = 0; k < 3; k++) begin : g_row
    osa_ed_ram #(.WIDTH(W), .DEPTH(MAX_LEN)) u_row (
      .clk(clk), .we(cmd.sweep && cur_sel == 2'(k)), .waddr(col), .wdata(v),
      .raddr(row_raddr), .rdata(row_rdata[k])
    );
  end

  assign prev_sel  = (cur_sel == 2'd0) ? 2'd2 : cur_sel - 2'd1;
  assign older_sel = (prev_sel == 2'd0) ? 2'd2 : prev_sel - 2'd1;

  // cell (i, j) with i = ri + 1, j = col + 1; row 0 is j itself
  always_comb begin
    j       = W'(col) + W'(1);
    prev_j  = (ri == '0) ? j : row_rdata[prev_sel];
    older_j = (ri == AW'(1)) ? j : row_rdata[older_sel];
    sub     = prev_left + ((a == t2_rdata) ? W'(0) : W'(1));
    v0      = (prev_j < cur_left) ? prev_j + W'(1) : cur_left + W'(1);
    v1      = (sub < v0) ? sub : v0;
    v       = v1;
    if (use_tr && ri != '0 && col != '0 && a == b_prev && a_prev == t2_rdata &&
        o2 + W'(1) < v1) begin
      v = o2 + W'(1);
    end
  end

  always_comb begin
    if (n1 == '0) result = W'(n2);
    else if (n2 == '0) result = W'(n1);
    else result = cur_left;
  end

  assign status.n1_zero  = (n1 == '0);
  assign status.n2_zero  = (n2 == '0);
  assign status.last_col = (LW'(col) + LW'(1) == n2);
  assign status.last_row = (LW'(ri) + LW'(1) == n1);
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_tr    <= 1'b1;
      n1        <= '0;
      n2        <= '0;
      ovf       <= 1'b0;
      cur_sel   <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) use_tr <= cfg_wdata;
      if (app1) n1 <= n1 + LW'(1);
      if (app2) n2 <= n2 + LW'(1);
      if (take && ((mode == MODE_FIRST && full1) || (mode == MODE_SECOND && full2))) begin
        ovf <= 1'b1;
      end
      if (cmd.row_end) cur_sel <= (cur_sel == 2'd2) ? 2'd0 : cur_sel + 2'd1;
      if (cmd.finish) begin
        out_valid <= 1'b1;
        n1        <= '0;
        n2        <= '0;
        ovf       <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.first_row) ri <= '0;
    if (cmd.row_end) ri <= ri + AW'(1);
    if (cmd.row_load) begin
      a         <= t1_rdata;
      a_prev    <= a;
      col       <= '0;
      cur_left  <= W'(ri) + W'(1);
      prev_left <= W'(ri);
      o1        <= W'(ri) - W'(1);
    end
    if (cmd.sweep) begin
      col       <= col + AW'(1);
      cur_left  <= v;
      prev_left <= prev_j;
      o1        <= older_j;
      o2        <= o1;
      b_prev    <= t2_rdata;
    end
    if (cmd.finish) begin
      distance <= (32'(result) > 32'(DIST_MAX)) ? 7'(DIST_MAX) : 7'(result);
      overflow <= ovf;
    end
  end

endmodule

[rtl/core/osa_edit_distance.sv]
// Edit distance engine (Levenshtein / optimal string alignment).
// Input channel (in_valid, in_stall, mode, char_code): mode 0 appends
// char_code to string one, mode 1 to string two, mode 2 computes the distance
// and clears both strings; mode 3 is dropped. Each string keeps up to MAX_LEN
// chars; extra chars are dropped and flag overflow on the next result.
// Output channel (out_valid, out_stall, distance, overflow): one result per
// compute request, held in an output register until taken.
// cfg_we / cfg_wdata write use_transpositions (reset 1); the user must do so
// only while idle, which the block does not enforce. A compute request walks
// the DP matrix one cell per cycle through shared row buffers, with a
// row-load step before each row and a row-end step between rows; the sweep
// is skipped if either string is empty. in_stall is high while the request
// is in progress, until the result register is loaded.
// If out_stall holds an earlier result, appends still go through; a new
// compute finishes its sweep and then waits for the output register.
// Synchronous reset empties both strings, clears out_valid and sets
// use_transpositions.
module osa_edit_distance
  import osa_ed_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [7:0] char_code,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] distance,
  output logic       overflow
);

  osa_ed_cmd_t    cmd;
  osa_ed_status_t status;

  osa_ed_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .mode(mode),
    .status(status), .cmd(cmd)
  );

  osa_ed_dpath #(.MAX_LEN(MAX_LEN)) u_dpath (
    .clk(clk), .rst(rst), .in_valid(in_valid), .mode(mode),
    .char_code(char_code), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_stall(out_stall), .out_valid(out_valid), .distance(distance),
    .overflow(overflow), .cmd(cmd), .status(status)
  );

  assign in_stall = cmd.busy;

endmodule

[rtl/core/osa_ed_checker.sv]
module osa_ed_checker
  import osa_ed_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] mode,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] distance,
  input logic       overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(distance) && $stable(overflow))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result visible after reset");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && mode == MODE_COMPUTE |=> in_stall)
    else $error("compute request did not hold off input");

  a_result_from_compute: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a compute in progress");

endmodule

bind osa_edit_distance osa_ed_checker u_osa_ed_checker (.*);
